[hdl/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg
// shared types and opcode codes for the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // quotient bits produced by the long division (bit 32 down to bit 0)
  localparam int QUO_BITS = 33;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic               overflow;
    logic               div_by_zero;
  } cau_out_t;

  // payload that runs through the division steps
  typedef struct packed {
    logic [1:0]          opcode;
    logic                dz;
    logic                neg_re;
    logic                neg_im;
    logic                big_re;
    logic                big_im;
    logic [64:0]         mag_re;
    logic [64:0]         mag_im;
    logic [63:0]         den;
    logic [63:0]         rem_re;
    logic [63:0]         rem_im;
    logic [QUO_BITS-1:0] xlo_re;
    logic [QUO_BITS-1:0] xlo_im;
    logic [QUO_BITS-1:0] q_re;
    logic [QUO_BITS-1:0] q_im;
  } cau_div_t;

endpackage

[hdl/cau_div_stage.sv]
// ----------------------------------------------------------------------------
// cau_div_stage
// one registered restoring-division step for the real and imaginary quotients
// ----------------------------------------------------------------------------
module cau_div_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cau_pkg::cau_div_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cau_pkg::cau_div_t out_data
);

  logic [64:0]       try_re, try_im;
  logic              ge_re, ge_im;
  cau_pkg::cau_div_t nxt;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    try_re = {in_data.rem_re, in_data.xlo_re[cau_pkg::QUO_BITS-1]};
    try_im = {in_data.rem_im, in_data.xlo_im[cau_pkg::QUO_BITS-1]};
    ge_re  = try_re >= {1'b0, in_data.den};
    ge_im  = try_im >= {1'b0, in_data.den};
    nxt        = in_data;
    nxt.rem_re = ge_re ? 64'(try_re - {1'b0, in_data.den}) : try_re[63:0];
    nxt.rem_im = ge_im ? 64'(try_im - {1'b0, in_data.den}) : try_im[63:0];
    nxt.xlo_re = {in_data.xlo_re[cau_pkg::QUO_BITS-2:0], 1'b0};
    nxt.xlo_im = {in_data.xlo_im[cau_pkg::QUO_BITS-2:0], 1'b0};
    nxt.q_re   = {in_data.q_re[cau_pkg::QUO_BITS-2:0], ge_re};
    nxt.q_im   = {in_data.q_im[cau_pkg::QUO_BITS-2:0], ge_im};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= nxt;
    end
  end

endmodule

[hdl/complex_arith_unit_top.sv]
// ----------------------------------------------------------------------------
// complex_arith_unit_top
// pipelined complex add, subtract, multiply and divide on signed fixed point
// ----------------------------------------------------------------------------
//
//  channel  | ports                          | item
//  ---------+--------------------------------+---------------------------------
//  input    | in_valid, in_ready, in_data    | opcode and two complex operands
//  output   | out_valid, out_ready, out_data | result, overflow, div_by_zero
//
// one item per cycle while the output is not stalled; every item runs through the
// 33 quotient steps of the divider pipeline (all opcodes use it)
// stages: products, sums, sign/magnitude, rounding/divide setup, 33 divide
// steps, saturation into the output register
// each stage holds while its successor is full and stalled, so bubbles close
// up and nothing is dropped or repeated; rst is synchronous and clears valids
module complex_arith_unit_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cau_pkg::cau_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cau_pkg::cau_out_t out_data
);

  localparam int XW    = 65 + FRAC_BITS;
  localparam int NDIV  = cau_pkg::QUO_BITS;

  // stage 1: products and short sums
  logic               v1, r1;
  logic [1:0]         op1;
  logic signed [63:0] p_ac, p_bd, p_bc, p_ad, p_cc, p_dd;
  logic signed [32:0] s_re, s_im;

  // stage 2: wide numerators and divisor
  logic               v2, r2;
  logic [1:0]         op2;
  logic signed [65:0] n_re, n_im;
  logic [63:0]        den2;

  // stage 3: sign and magnitude
  logic               v3, r3;
  logic [1:0]         op3;
  logic               neg3_re, neg3_im, dz3;
  logic [64:0]        mag3_re, mag3_im;
  logic [63:0]        den3;

  // stage 4: rounding and divide setup
  logic               v4, r4;
  cau_pkg::cau_div_t  d4, d4_next;

  // divide step chain
  logic              dv   [NDIV+1];
  logic              drdy [NDIV+1];
  cau_pkg::cau_div_t dd   [NDIV+1];

  logic              r_out;
  cau_pkg::cau_out_t res_next;

  // saturate a sign and magnitude value; bit 32 carries the overflow
  function automatic logic [32:0] sat32(input logic neg, input logic [64:0] mag);
    logic [32:0] r;
    if (!neg) begin
      if (mag > 65'h7fffffff) r = {1'b1, 32'h7fffffff};
      else                    r = {1'b0, mag[31:0]};
    end else begin
      if (mag > 65'h80000000) r = {1'b1, 32'h80000000};
      else                    r = {1'b0, 32'(33'd0 - mag[32:0])};
    end
    return r;
  endfunction

  assign r_out = !out_valid || out_ready;
  assign r4    = !v4 || drdy[0];
  assign r3    = !v3 || r4;
  assign r2    = !v2 || r3;
  assign r1    = !v1 || r2;
  assign in_ready = r1;

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= in_valid;
    end
    if (r1 && in_valid) begin
      op1  <= in_data.opcode;
      p_ac <= in_data.a_re * in_data.b_re;
      p_bd <= in_data.a_im * in_data.b_im;
      p_bc <= in_data.a_im * in_data.b_re;
      p_ad <= in_data.a_re * in_data.b_im;
      p_cc <= in_data.b_re * in_data.b_re;
      p_dd <= in_data.b_im * in_data.b_im;
      // add or subtract only needs one extra bit
      if (in_data.opcode == cau_pkg::OP_SUB) begin
        s_re <= {in_data.a_re[31], in_data.a_re} - {in_data.b_re[31], in_data.b_re};
        s_im <= {in_data.a_im[31], in_data.a_im} - {in_data.b_im[31], in_data.b_im};
      end else begin
        s_re <= {in_data.a_re[31], in_data.a_re} + {in_data.b_re[31], in_data.b_re};
        s_im <= {in_data.a_im[31], in_data.a_im} + {in_data.b_im[31], in_data.b_im};
      end
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
    if (r2 && v1) begin
      op2  <= op1;
      den2 <= 64'(p_cc) + 64'(p_dd);
      case (op1)
        cau_pkg::OP_MUL: begin
          n_re <= {{2{p_ac[63]}}, p_ac} - {{2{p_bd[63]}}, p_bd};
          n_im <= {{2{p_bc[63]}}, p_bc} + {{2{p_ad[63]}}, p_ad};
        end
        cau_pkg::OP_DIV: begin
          n_re <= {{2{p_ac[63]}}, p_ac} + {{2{p_bd[63]}}, p_bd};
          n_im <= {{2{p_bc[63]}}, p_bc} - {{2{p_ad[63]}}, p_ad};
        end
        default: begin
          n_re <= {{33{s_re[32]}}, s_re};
          n_im <= {{33{s_im[32]}}, s_im};
        end
      endcase
    end
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (r3) begin
      v3 <= v2;
    end
    if (r3 && v2) begin
      op3     <= op2;
      den3    <= den2;
      dz3     <= den2 == 64'd0;
      neg3_re <= n_re[65];
      neg3_im <= n_im[65];
      mag3_re <= n_re[65] ? 65'(66'd0 - n_re) : n_re[64:0];
      mag3_im <= n_im[65] ? 65'(66'd0 - n_im) : n_im[64:0];
    end
  end

  // stage 4: floor shift for multiply, first remainder and overflow test for divide
  always_comb begin
    logic [64:0]   rnd;
    logic [XW-1:0] x_re, x_im;
    logic [XW-34:0] h_re, h_im;
    rnd  = 65'((65'd1 << FRAC_BITS) - 65'd1);
    x_re = XW'(mag3_re) << FRAC_BITS;
    x_im = XW'(mag3_im) << FRAC_BITS;
    h_re = x_re[XW-1:NDIV];
    h_im = x_im[XW-1:NDIV];
    d4_next        = '0;
    d4_next.opcode = op3;
    d4_next.dz     = dz3;
    d4_next.neg_re = neg3_re;
    d4_next.neg_im = neg3_im;
    d4_next.den    = den3;
    d4_next.mag_re = mag3_re;
    d4_next.mag_im = mag3_im;
    if (op3 == cau_pkg::OP_MUL) begin
      d4_next.mag_re = neg3_re ? 65'(mag3_re + rnd) >> FRAC_BITS : mag3_re >> FRAC_BITS;
      d4_next.mag_im = neg3_im ? 65'(mag3_im + rnd) >> FRAC_BITS : mag3_im >> FRAC_BITS;
    end
    // a quotient of 2^33 or more is saturated anyway
    d4_next.big_re = 64'(h_re) >= den3;
    d4_next.big_im = 64'(h_im) >= den3;
    d4_next.rem_re = 64'(h_re);
    d4_next.rem_im = 64'(h_im);
    d4_next.xlo_re = x_re[NDIV-1:0];
    d4_next.xlo_im = x_im[NDIV-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (r4) begin
      v4 <= v3;
    end
    if (r4 && v3) begin
      d4 <= d4_next;
    end
  end

  assign dv[0] = v4;
  assign dd[0] = d4;

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    cau_div_stage u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv[k]),
      .in_ready  (drdy[k]),
      .in_data   (dd[k]),
      .out_valid (dv[k+1]),
      .out_ready (drdy[k+1]),
      .out_data  (dd[k+1])
    );
  end

  assign drdy[NDIV] = r_out;

  // final stage: pick result, saturate, flags
  always_comb begin
    logic [64:0] m_re, m_im;
    logic [32:0] p_re, p_im;
    cau_pkg::cau_div_t f;
    f    = dd[NDIV];
    m_re = f.mag_re;
    m_im = f.mag_im;
    if (f.opcode == cau_pkg::OP_DIV) begin
      m_re = f.big_re ? 65'h1_0000_0000 : 65'(f.q_re);
      m_im = f.big_im ? 65'h1_0000_0000 : 65'(f.q_im);
    end
    p_re = sat32(f.neg_re, m_re);
    p_im = sat32(f.neg_im, m_im);
    res_next.res_re      = p_re[31:0];
    res_next.res_im      = p_im[31:0];
    res_next.overflow    = p_re[32] | p_im[32];
    res_next.div_by_zero = 1'b0;
    if (f.opcode == cau_pkg::OP_DIV && f.dz) begin
      res_next.res_re      = '0;
      res_next.res_im      = '0;
      res_next.overflow    = 1'b0;
      res_next.div_by_zero = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (r_out) begin
      out_valid <= dv[NDIV];
    end
    if (r_out && dv[NDIV]) begin
      out_data <= res_next;
    end
  end

  // zero divisor gives a clean zero result
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.div_by_zero |->
      out_data.res_re == 32'sd0 && out_data.res_im == 32'sd0 && !out_data.overflow)
    else $error("divide by zero result not clean");

  // overflow only with a saturated part
  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.overflow |->
      out_data.res_re == 32'h7fffffff || out_data.res_re == 32'h80000000 ||
      out_data.res_im == 32'h7fffffff || out_data.res_im == 32'h80000000)
    else $error("overflow without saturation");

  // input backs off only when the whole pipe is full behind a stalled output
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready && v1 && v4)
    else $error("input stalled with room in the pipeline");

endmodule

[verif/complex_arith_unit_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// complex_arith_unit_checker
// watches both channels of the complex arithmetic unit, works out the result
// of every accepted item and compares it with what comes out
// ----------------------------------------------------------------------------
module complex_arith_unit_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  cau_pkg::cau_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  cau_pkg::cau_out_t out_data,
  output int                errors,
  output int                waiting,
  output int                checked
);

  cau_pkg::cau_out_t pending_results[$];

  // clamp to the signed 32-bit range, flag any clamping
  function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic ovf);
    if (v > 128'sh7FFFFFFF) begin
      ovf = 1'b1;
      return 32'h7FFFFFFF;
    end
    if (v < -128'sh80000000) begin
      ovf = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  // num * 2^FRAC_BITS / den, truncated toward zero
  function automatic logic signed [127:0] frac_quot(input logic signed [127:0] num,
                                                     input logic [127:0] den);
    logic [127:0] mag;
    logic [127:0] q;
    mag = num[127] ? -num : num;
    q = (mag << FRAC_BITS) / den;
    return num[127] ? -$signed(q) : $signed(q);
  endfunction

  function automatic cau_pkg::cau_out_t complex_result(input cau_pkg::cau_in_t it);
    logic signed [127:0] a, b, c, d, re, im;
    logic [127:0] den;
    cau_pkg::cau_out_t r;
    logic ovf;
    a = it.a_re;
    b = it.a_im;
    c = it.b_re;
    d = it.b_im;
    ovf = 1'b0;
    r = '0;
    case (it.opcode)
      cau_pkg::OP_ADD: begin
        re = a + c;
        im = b + d;
      end
      cau_pkg::OP_SUB: begin
        re = a - c;
        im = b - d;
      end
      cau_pkg::OP_MUL: begin
        re = (a * c - b * d) >>> FRAC_BITS;
        im = (b * c + a * d) >>> FRAC_BITS;
      end
      default: begin
        den = c * c + d * d;
        if (den == 0) begin
          r.div_by_zero = 1'b1;
          return r;
        end
        re = frac_quot(a * c + b * d, den);
        im = frac_quot(b * c - a * d, den);
      end
    endcase
    r.res_re = clamp32(re, ovf);
    r.res_im = clamp32(im, ovf);
    r.overflow = ovf;
    return r;
  endfunction

  initial begin
    errors = 0;
    checked = 0;
  end

  assign waiting = pending_results.size();

  always @(posedge clk) begin
    cau_pkg::cau_out_t want;
    if (!rst) begin
      if (in_valid && in_ready)
        pending_results.push_back(complex_result(in_data));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, out_data);
        end else begin
          want = pending_results.pop_front();
          checked++;
          if (want.res_re !== out_data.res_re) begin
            errors++;
            $display("%0t: res_re expected %h actual %h", $time, want.res_re, out_data.res_re);
          end
          if (want.res_im !== out_data.res_im) begin
            errors++;
            $display("%0t: res_im expected %h actual %h", $time, want.res_im, out_data.res_im);
          end
          if (want.overflow !== out_data.overflow) begin
            errors++;
            $display("%0t: overflow expected %b actual %b", $time, want.overflow,
                     out_data.overflow);
          end
          if (want.div_by_zero !== out_data.div_by_zero) begin
            errors++;
            $display("%0t: div_by_zero expected %b actual %b", $time, want.div_by_zero,
                     out_data.div_by_zero);
          end
        end
      end
    end
  end

endmodule

[verif/complex_arith_unit_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// complex_arith_unit_top_test
// drives directed corner items and random operand pairs through the unit
// with bursty input and random output stalls; a checker predicts each result
// ----------------------------------------------------------------------------
module complex_arith_unit_top_test;

  localparam int  RANDOM_ITEMS = 800;
  localparam int  LATENCY      = 38;
  localparam int  CYCLE_LIMIT  = 400000;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  cau_pkg::cau_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  cau_pkg::cau_out_t out_data;
  int                errors;
  int                waiting;
  int                checked;
  int                cycles;
  int                op_count[4];
  int                stall_mode;

  complex_arith_unit_top dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  complex_arith_unit_checker chk (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .errors   (errors),
    .waiting  (waiting),
    .checked  (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog, generous against the slowest correct run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // receiver: stall pattern changes mode every so often
  // mode 0 always ready, 1 mostly ready, 2 long stalls
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0)
      stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // operand with a bias toward small, extreme and near-one values
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 3)
                                           : 32'h80000000 + $urandom_range(0, 3);
      2:       return $urandom_range(0, 1) ? 32'(65536) : -32'(65536);
      3:       return 32'($signed($urandom_range(0, 4000)) - 2000);
      default: return 32'($signed($urandom_range(0, 32'h01000000)) - 32'sh00800000);
    endcase
  endfunction

  // present one item and hold it until accepted; valid stays high after
  task automatic send_item(input logic [1:0] op, input logic [31:0] ar,
                           input logic [31:0] ai, input logic [31:0] br,
                           input logic [31:0] bi);
    in_valid       <= 1'b1;
    in_data.opcode <= op;
    in_data.a_re   <= ar;
    in_data.a_im   <= ai;
    in_data.b_re   <= br;
    in_data.b_im   <= bi;
    op_count[op]++;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // idle gap after a burst; send_item never drops valid, only this task and the end of the test do
  task automatic sender_gap(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  localparam logic [31:0] MAXV = 32'h7FFFFFFF;
  localparam logic [31:0] MINV = 32'h80000000;
  localparam logic [31:0] ONE  = 32'h00010000;

  initial begin
    int burst;
    logic [1:0] op;
    logic [31:0] br, bi;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    stall_mode = 0;
    cycles     = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed corners
    send_item(cau_pkg::OP_ADD, MAXV, MINV, MAXV, MINV);           // saturate both ways
    send_item(cau_pkg::OP_ADD, MAXV, 32'hFFFFFFFF, 32'h0, 32'h1); // no overflow at the edge
    send_item(cau_pkg::OP_SUB, MINV, MAXV, MAXV, MINV);
    send_item(cau_pkg::OP_SUB, 32'h0, 32'h0, MINV, 32'h0);        // negating the minimum
    send_item(cau_pkg::OP_MUL, MINV, MINV, MINV, MINV);
    send_item(cau_pkg::OP_MUL, MAXV, MAXV, MAXV, MINV);
    send_item(cau_pkg::OP_MUL, 32'hFFFFFFFF, 32'h0, 32'h1, 32'h0); // floor of a tiny negative
    send_item(cau_pkg::OP_MUL, ONE, ONE, ONE, 32'hFFFF0000);
    send_item(cau_pkg::OP_DIV, ONE, ONE, 32'h0, 32'h0);           // zero divisor
    send_item(cau_pkg::OP_DIV, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(cau_pkg::OP_DIV, 32'h00020000, 32'h00020000, ONE, ONE);
    send_item(cau_pkg::OP_DIV, MAXV, MINV, 32'h1, 32'h0);         // quotient far out of range
    send_item(cau_pkg::OP_DIV, MINV, MINV, MINV, MINV);
    send_item(cau_pkg::OP_DIV, 32'hFFFFFFFF, 32'h0, MAXV, MAXV);  // truncation toward zero
    send_item(cau_pkg::OP_DIV, ONE, 32'h0, 32'h0, 32'hFFFFFFFF);
    send_item(cau_pkg::OP_ADD, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(cau_pkg::OP_SUB, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_item(cau_pkg::OP_MUL, 32'h0, 32'h0, 32'h0, 32'h0);

    // random bursts; some stretches with back-to-back items only
    for (int n = 0; n < RANDOM_ITEMS; ) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && n < RANDOM_ITEMS; k++, n++) begin
        op = 2'($urandom_range(0, 3));
        br = pick_operand();
        bi = pick_operand();
        if (op == cau_pkg::OP_DIV && $urandom_range(0, 15) == 0) begin
          br = '0;
          bi = '0;
        end
        send_item(op, pick_operand(), pick_operand(), br, bi);
      end
      sender_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
    end
    in_valid <= 1'b0;

    wait (waiting == 0);
    repeat (2 * LATENCY) @(negedge clk);

    $display("items by opcode: add %0d sub %0d mul %0d div %0d", op_count[cau_pkg::OP_ADD],
             op_count[cau_pkg::OP_SUB], op_count[cau_pkg::OP_MUL], op_count[cau_pkg::OP_DIV]);
    $display("%0d results checked, %0d mismatches", checked, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
